// ===== rtl/kpis_pkg.sv =====
// Shared types and constants of the key/payload insertion sorter.
// No dependencies; used by kpis_ctrl, kpis_datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package kpis_pkg;

    localparam int unsigned KEY_W = 32;
    localparam int unsigned PAY_W = 32;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [PAY_W-1:0]        pay_t;

    typedef enum logic [0:0] {
        ST_LOAD,
        ST_DRAIN
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic insert;     // place the incoming item into the sorted row
        logic shift;      // move the row down by one entry (entry 0 leaves)
        logic set_drop;   // an item was lost because the row is full
        logic clear_drop; // run finished
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic one_left;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/kpis_ctrl.sv =====
// Controller of the insertion sorter: load / drain state machine.
// Depends on kpis_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kpis_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             in_last,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire kpis_pkg::status_t status,
    output kpis_pkg::cmd_t        cmd
);

    kpis_pkg::state_t state_reg;
    kpis_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kpis_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd        = '0;
        case (state_reg)
            kpis_pkg::ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.insert   = !status.full;
                    cmd.set_drop = status.full;
                    if (in_last)
                    begin
                        state_next = kpis_pkg::ST_DRAIN;
                    end
                end
            end
            kpis_pkg::ST_DRAIN:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.shift = 1'b1;
                    if (status.one_left)
                    begin
                        cmd.clear_drop = 1'b1;
                        state_next     = kpis_pkg::ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = kpis_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/kpis_datapath.sv =====
// Datapath of the insertion sorter: a row of key/payload entries with
// parallel compare-and-shift insertion and a shift-down drain.
// Depends on kpis_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kpis_datapath #(
    parameter int unsigned DEPTH = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire kpis_pkg::cmd_t    cmd,
    input  wire kpis_pkg::key_t    in_key,
    input  wire kpis_pkg::pay_t    in_pay,
    output kpis_pkg::status_t      status,
    output kpis_pkg::key_t         head_key,
    output kpis_pkg::pay_t         head_pay,
    output logic                   dropped
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    kpis_pkg::key_t   key_reg [DEPTH];
    kpis_pkg::pay_t   pay_reg [DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             dropped_reg;
    logic             dropped_next;
    logic [DEPTH-1:0] gt;

    // entries holding a key strictly greater than the new one move up;
    // the row is sorted, so these form a contiguous upper block
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            gt[i] = (CNT_W'(i) < count_reg) && (key_reg[i] > in_key);
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_entry
        logic from_prev;
        logic take_new;

        if (i == 0)
        begin : g_first
            assign from_prev = 1'b0;
        end
        else
        begin : g_rest
            assign from_prev = gt[i-1];
        end

        assign take_new = gt[i] || (CNT_W'(i) == count_reg);

        always_ff @(posedge clk)
        begin
            if (cmd.insert)
            begin
                if (from_prev)
                begin
                    key_reg[i] <= key_reg[(i > 0) ? i - 1 : 0];
                    pay_reg[i] <= pay_reg[(i > 0) ? i - 1 : 0];
                end
                else if (take_new)
                begin
                    key_reg[i] <= in_key;
                    pay_reg[i] <= in_pay;
                end
            end
            else if (cmd.shift && (i < DEPTH - 1))
            begin
                key_reg[i] <= key_reg[(i < DEPTH - 1) ? i + 1 : i];
                pay_reg[i] <= pay_reg[(i < DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.shift)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        dropped_next = dropped_reg;
        if (cmd.clear_drop)
        begin
            dropped_next = 1'b0;
        end
        else if (cmd.set_drop)
        begin
            dropped_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    assign status.full     = (count_reg == CNT_W'(DEPTH));
    assign status.one_left = (count_reg == CNT_W'(1));
    assign head_key        = key_reg[0];
    assign head_pay        = pay_reg[0];
    assign dropped         = dropped_reg;

endmodule

`default_nettype wire

// ===== rtl/key_payload_insertion_sort.sv =====
// Top level of the stable key/payload insertion sorter.
// Depends on kpis_pkg, kpis_ctrl and kpis_datapath.
//
//  Port group   Dir  tdata                         tlast        tuser
//  s_t*         in   [31:0] score, [63:32] payload last         -
//  m_t*         out  [31:0] sorted_score,          end_of_run   overflow
//                    [63:32] sorted_payload
//
//  Loading: one item per cycle; all entries compare against the new key
//  in parallel and shift up in the same cycle.
//  Drain: after the last item, one result per cycle from entry 0 while the
//  row shifts down. Input is not accepted during the drain. A stalled
//  m_tready holds the current result.
//  Reset clears the fill count, the drop flag and the state; entries need none.
`timescale 1ns / 1ps
`default_nettype none

module key_payload_insertion_sort #(
    parameter int unsigned DEPTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,  // [31:0] score, [63:32] payload
    input  wire logic        s_tlast,  // last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,  // [31:0] sorted_score, [63:32] sorted_payload
    output logic             m_tlast,  // end_of_run
    output logic             m_tuser   // [0] overflow
);

    kpis_pkg::cmd_t    cmd;
    kpis_pkg::status_t status;
    kpis_pkg::key_t    head_key;
    kpis_pkg::pay_t    head_pay;
    logic              dropped;

    kpis_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_last   (s_tlast),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    kpis_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_key   (kpis_pkg::key_t'(s_tdata[31:0])),
        .in_pay   (s_tdata[63:32]),
        .status   (status),
        .head_key (head_key),
        .head_pay (head_pay),
        .dropped  (dropped)
    );

    assign m_tdata = {head_pay, head_key};
    assign m_tlast = status.one_left;
    assign m_tuser = dropped;

endmodule

`default_nettype wire

// ===== bench/key_payload_insertion_sort_test.sv =====
// Self-checking bench for key_payload_insertion_sort: stable ascending order,
// end-of-run flag and the drop flag on runs beyond the store size.
// Depends on kpis_pkg and the key_payload_insertion_sort RTL.
`timescale 1ns / 1ps

module key_payload_insertion_sort_test;

    localparam int DEPTH       = 32;
    localparam int ITEM_TARGET = 500;
    localparam int QUIET_AFTER = 420;   // no idling on either side past this item count
    localparam int LONG_HOLD   = 200;
    localparam int IDLE_LIMIT  = 2000;

    localparam kpis_pkg::key_t SCORE_MIN  = kpis_pkg::key_t'(32'h8000_0000);
    localparam kpis_pkg::key_t SCORE_MAX  = kpis_pkg::key_t'(32'h7fff_ffff);
    localparam kpis_pkg::key_t SCORE_NEG1 = kpis_pkg::key_t'(32'hffff_ffff);
    localparam kpis_pkg::key_t Q16_ONE    = kpis_pkg::key_t'(32'h0001_0000);
    localparam kpis_pkg::pay_t PAY_ONES   = kpis_pkg::pay_t'(32'hffff_ffff);

    typedef struct {
        kpis_pkg::key_t score;
        kpis_pkg::pay_t payload;
        bit             end_of_run;
        bit             overflow;
    } sorted_entry_t;

    // Mirrors the sorted row and queues the entries each run should emit.
    class sorted_run_tracker;
        kpis_pkg::key_t held_keys[$];
        kpis_pkg::pay_t held_pays[$];
        bit             lost_item;
        sorted_entry_t  awaited[$];
        int             mismatches;
        int             results_checked;
        int             overflow_runs;

        function new();
            lost_item       = 1'b0;
            mismatches      = 0;
            results_checked = 0;
            overflow_runs   = 0;
        endfunction

        function void flag_error(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] MISMATCH: %s", $time, msg);
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void note_item(kpis_pkg::key_t k, kpis_pkg::pay_t p, bit lst);
            int            pos;
            sorted_entry_t e;
            if (held_keys.size() >= DEPTH)
            begin
                lost_item = 1'b1;
            end
            else
            begin
                // strict greater-than keeps equal keys in arrival order
                pos = held_keys.size();
                while (pos > 0 && held_keys[pos-1] > k)
                    pos--;
                held_keys.insert(pos, k);
                held_pays.insert(pos, p);
            end
            if (lst)
            begin
                if (lost_item)
                    overflow_runs++;
                foreach (held_keys[i])
                begin
                    e.score      = held_keys[i];
                    e.payload    = held_pays[i];
                    e.end_of_run = (i == held_keys.size() - 1);
                    e.overflow   = lost_item;
                    awaited.push_back(e);
                end
                held_keys.delete();
                held_pays.delete();
                lost_item = 1'b0;
            end
        endfunction

        function void check_result(logic [63:0] data, logic eor, logic ovf);
            sorted_entry_t e;
            results_checked++;
            if (awaited.size() == 0)
            begin
                flag_error($sformatf("unexpected result score=%h payload=%h last=%b ovf=%b",
                                     data[31:0], data[63:32], eor, ovf));
                return;
            end
            e = awaited.pop_front();
            if (data[31:0] !== e.score || data[63:32] !== e.payload ||
                eor !== e.end_of_run || ovf !== e.overflow)
                flag_error({
                    $sformatf("exp score=%h payload=%h last=%b ovf=%b, ",
                              e.score, e.payload, e.end_of_run, e.overflow),
                    $sformatf("got score=%h payload=%h last=%b ovf=%b",
                              data[31:0], data[63:32], eor, ovf)});
        endfunction

        function void close_out();
            if (awaited.size() != 0)
                flag_error($sformatf("%0d sorted results never arrived", awaited.size()));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // [31:0] score, [63:32] payload
    logic        s_tlast;   // last
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // [31:0] sorted_score, [63:32] sorted_payload
    logic        m_tlast;   // end_of_run
    logic        m_tuser;   // [0] overflow

    sorted_run_tracker tracker;
    bit quiet;
    bit hold_output;
    int items_sent;
    int runs_sent;
    int idle_cycles;

    key_payload_insertion_sort #(.DEPTH(DEPTH)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic kpis_pkg::key_t pick_score();
        case ($urandom_range(0, 3))
            0, 1: return kpis_pkg::key_t'($urandom);
            // small Q16.16 set so equal keys show up often
            2: return kpis_pkg::key_t'((int'($urandom_range(0, 6)) - 3) * 65536);
            default:
                case ($urandom_range(0, 3))
                    0: return SCORE_MIN;
                    1: return SCORE_MAX;
                    2: return '0;
                    default: return SCORE_NEG1;
                endcase
        endcase
    endfunction

    task automatic offer_item(input kpis_pkg::key_t k, input kpis_pkg::pay_t p,
                              input bit lst);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {p, k};
        s_tlast  <= lst;
        do @(posedge clk); while (!s_tready);
        tracker.note_item(k, p, lst);
        items_sent++;
        if (lst)
            runs_sent++;
    endtask

    task automatic send_random_run(input int len, input bit stall_drain);
        for (int i = 0; i < len; i++)
        begin
            // hold the receiver off right as the drain begins
            if (stall_drain && i == len - 1)
                hold_output = 1'b1;
            offer_item(pick_score(), kpis_pkg::pay_t'($urandom), i == len - 1);
        end
    endtask

    task automatic wait_results_drained();
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_result(m_tdata, m_tlast, m_tuser);
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // receiver: random stall bursts, one long hold on request
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_output)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_output = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                gap = $urandom_range(1, 10);
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    initial
    begin
        int len;
        tracker     = new();
        quiet       = 1'b0;
        hold_output = 1'b0;
        items_sent  = 0;
        runs_sent   = 0;
        idle_cycles = 0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: lone item, extremes, ties, reversed pair
        offer_item(SCORE_MIN, '0, 1'b1);
        offer_item(SCORE_MAX, PAY_ONES, 1'b0);
        offer_item('0, kpis_pkg::pay_t'(32'h0000_0001), 1'b0);
        offer_item(SCORE_NEG1, kpis_pkg::pay_t'(32'haaaa_aaaa), 1'b0);
        offer_item(kpis_pkg::key_t'(5 * 65536), kpis_pkg::pay_t'(32'h0000_0011), 1'b0);
        offer_item(kpis_pkg::key_t'(5 * 65536), kpis_pkg::pay_t'(32'h0000_0022), 1'b0);
        offer_item(SCORE_MIN, kpis_pkg::pay_t'(32'h5555_5555), 1'b0);
        offer_item(kpis_pkg::key_t'(5 * 65536), kpis_pkg::pay_t'(32'h0000_0033), 1'b0);
        offer_item(SCORE_MAX, kpis_pkg::pay_t'(32'h1234_5678), 1'b0);
        offer_item(SCORE_MIN, kpis_pkg::pay_t'(32'h8765_4321), 1'b0);
        offer_item(Q16_ONE, PAY_ONES, 1'b1);
        offer_item(kpis_pkg::key_t'(7 * 65536), kpis_pkg::pay_t'(32'h0000_0007), 1'b0);
        offer_item(kpis_pkg::key_t'(-7 * 65536), kpis_pkg::pay_t'(32'hffff_fff9), 1'b1);
        offer_item('0, '0, 1'b0);
        offer_item('0, PAY_ONES, 1'b1);
        s_tvalid <= 1'b0;
        wait_results_drained();

        // random runs; first three hit exactly full, one drop, many drops
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= QUIET_AFTER)
                quiet = 1'b1;
            if (runs_sent == 4)
                len = 32;
            else if (runs_sent == 5)
                len = 33;
            else if (runs_sent == 6)
                len = 45;
            else if ($urandom_range(0, 9) == 0)
                len = $urandom_range(28, 40);
            else
                len = $urandom_range(1, 12);
            send_random_run(len, runs_sent == 9);
            if (runs_sent == 14)
            begin
                s_tvalid <= 1'b0;
                wait_results_drained();
            end
        end
        s_tvalid <= 1'b0;

        wait_results_drained();
        repeat (40) @(posedge clk);
        tracker.close_out();
        $display("Sorted %0d runs from %0d items into %0d results; %0d runs dropped items.",
                 runs_sent, items_sent, tracker.results_checked, tracker.overflow_runs);
        if (tracker.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
